// File: hdl/rmmp_pkg.sv
// shared constants, types and the channel fold function for the rgb min/max pool unit
// no dependencies; used by rgb_min_max_pool_2x2_unit

package rmmp_pkg;

    // widest input row that the line buffer is sized for
    localparam int MAX_WIDTH    = 4096;
    localparam int BUF_DEPTH    = (MAX_WIDTH + 1) / 2;
    localparam int ADDR_W       = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

    // column position and effective width
    localparam int COL_W        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CNT_W        = $clog2(MAX_WIDTH + 1);

    localparam int CFG_WIDTH_W  = 13;
    localparam int CFG_HEIGHT_W = 16;
    localparam int CFG_DATA_W   = 16;
    localparam int CMP_W        = (CFG_WIDTH_W > CNT_W) ? CFG_WIDTH_W : CNT_W;

    localparam int CH_W         = 8;
    localparam int PIX_W        = 3 * CH_W;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_MODE   = 2'd2
    } t_reg_idx;

    // pixel waiting in the middle stage for its line buffer entry
    typedef struct packed {
        logic [PIX_W-1:0] part;
        logic             lone;
        logic             eor;
        logic             eof;
    } t_stage;

    // per-channel min (max_sel = 0) or max (max_sel = 1) of two packed pixels
    function automatic logic [PIX_W-1:0] fold(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic max_sel);
        logic [PIX_W-1:0] res;
        logic [CH_W-1:0]  x;
        logic [CH_W-1:0]  y;
        for (int ch = 0; ch < 3; ch++) begin
            x = a[ch*CH_W +: CH_W];
            y = b[ch*CH_W +: CH_W];
            if (max_sel) begin
                res[ch*CH_W +: CH_W] = (x > y) ? x : y;
            end else begin
                res[ch*CH_W +: CH_W] = (x < y) ? x : y;
            end
        end
        return res;
    endfunction

endpackage

// File: hdl/rgb_min_max_pool_2x2_unit.sv
// top level of the 2x2 rgb min/max pooling unit
// depends on rmmp_pkg and rmmp_ram

// Takes one RGB pixel per clock in raster order and emits one pixel per 2x2 block, reduced
// per channel to the minimum (mode 0) or maximum (mode 1). A new pixel is taken every cycle
// as long as the output side keeps up; a result passes through the middle stage, where the
// registered read of the half-width line buffer ram that holds the folded pairs of the even
// row meets it, and then into the output register. Rows above MAX_WIDTH pixels are cut
// to MAX_WIDTH. Writing the width or height restarts the frame at row 0, column 0; the line
// buffer needs no clearing after reset. Configuration is always ready and is to be written
// only while no pixel is in flight.

module rgb_min_max_pool_2x2_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [1:0]                      i_cfg_index,
    input  logic [rmmp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input pixel stream
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [23:0]                     i_s_axis_tdata,   // red, green, blue
    // output pixel stream
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [23:0]                     o_m_axis_tdata,   // out_red, out_green, out_blue
    output logic                            o_m_axis_tlast,   // end_of_row
    output logic                            o_m_axis_tuser    // end_of_frame
);

    logic [rmmp_pkg::CFG_WIDTH_W-1:0]  r_width;
    logic [rmmp_pkg::CFG_HEIGHT_W-1:0] r_height;
    logic                              r_mode;

    logic [rmmp_pkg::COL_W-1:0]        r_col;
    logic [rmmp_pkg::CFG_HEIGHT_W-1:0] r_row;
    logic [rmmp_pkg::PIX_W-1:0]        r_held;

    logic                              r_s1_valid;
    rmmp_pkg::t_stage                  r_s1;

    logic                              r_out_valid;
    logic [rmmp_pkg::PIX_W-1:0]        r_out_data;
    logic                              r_out_eor;
    logic                              r_out_eof;

    logic [rmmp_pkg::CMP_W-1:0]        width_ext;
    logic [rmmp_pkg::CNT_W-1:0]        w_eff;
    logic [rmmp_pkg::CFG_HEIGHT_W-1:0] h_eff;
    logic [rmmp_pkg::CNT_W-1:0]        col_inc;
    logic [rmmp_pkg::CFG_HEIGHT_W:0]   row_inc;
    logic                              last_col;
    logic                              last_row;
    logic                              lone_row;
    logic                              odd_row;
    logic                              hold;
    logic                              emit;
    logic                              accept;
    logic                              cfg_accept;
    logic                              s1_free;
    logic                              out_free;
    logic [rmmp_pkg::PIX_W-1:0]        part;
    logic [rmmp_pkg::ADDR_W-1:0]       slot;
    logic [rmmp_pkg::PIX_W-1:0]        buf_q;
    logic [rmmp_pkg::PIX_W-1:0]        s1_res;
    logic [rmmp_pkg::COL_W-1:0]        n_col;
    logic [rmmp_pkg::CFG_HEIGHT_W-1:0] n_row;

    // effective frame size
    assign width_ext = rmmp_pkg::CMP_W'(r_width);
    always_comb begin
        if (r_width == '0) begin
            w_eff = rmmp_pkg::CNT_W'(1);
        end else if (width_ext > rmmp_pkg::CMP_W'(rmmp_pkg::MAX_WIDTH)) begin
            w_eff = rmmp_pkg::CNT_W'(rmmp_pkg::MAX_WIDTH);
        end else begin
            w_eff = rmmp_pkg::CNT_W'(width_ext);
        end
    end
    assign h_eff = (r_height == '0) ? rmmp_pkg::CFG_HEIGHT_W'(1) : r_height;

    // position of the incoming pixel
    assign col_inc  = rmmp_pkg::CNT_W'(r_col) + rmmp_pkg::CNT_W'(1);
    assign row_inc  = {1'b0, r_row} + (rmmp_pkg::CFG_HEIGHT_W + 1)'(1);
    assign last_col = (col_inc == w_eff);
    assign last_row = (row_inc == {1'b0, h_eff});
    assign lone_row = last_row && h_eff[0];
    assign odd_row  = r_row[0];
    assign hold     = !r_col[0] && !last_col;
    assign emit     = !hold && (lone_row || odd_row);
    assign slot     = rmmp_pkg::ADDR_W'(r_col >> 1);

    assign part = r_col[0] ? rmmp_pkg::fold(r_held, i_s_axis_tdata, r_mode) : i_s_axis_tdata;

    // handshakes
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign s1_free         = !r_s1_valid || out_free;
    assign o_s_axis_tready = s1_free;
    assign accept          = i_s_axis_tvalid && s1_free;
    assign o_cfg_ready     = 1'b1;
    assign cfg_accept      = i_cfg_valid;

    always_comb begin
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : row_inc[rmmp_pkg::CFG_HEIGHT_W-1:0];
        end else begin
            n_col = rmmp_pkg::COL_W'(col_inc);
            n_row = r_row;
        end
    end

    rmmp_ram #(
        .WIDTH (rmmp_pkg::PIX_W),
        .DEPTH (rmmp_pkg::BUF_DEPTH),
        .ADDR_W(rmmp_pkg::ADDR_W)
    ) u_line_buf (
        .i_clk  (i_clk),
        .i_we   (accept && !hold && !lone_row && !odd_row),
        .i_waddr(slot),
        .i_wdata(part),
        .i_re   (accept && emit && !lone_row),
        .i_raddr(slot),
        .o_rdata(buf_q)
    );

    assign s1_res = r_s1.lone ? r_s1.part : rmmp_pkg::fold(buf_q, r_s1.part, r_mode);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= rmmp_pkg::CFG_WIDTH_W'(640);
            r_height    <= rmmp_pkg::CFG_HEIGHT_W'(480);
            r_mode      <= 1'b1;
            r_col       <= '0;
            r_row       <= '0;
            r_held      <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_accept) begin
                case (i_cfg_index)
                    rmmp_pkg::REG_WIDTH: begin
                        r_width <= i_cfg_data[rmmp_pkg::CFG_WIDTH_W-1:0];
                    end
                    rmmp_pkg::REG_HEIGHT: begin
                        r_height <= i_cfg_data[rmmp_pkg::CFG_HEIGHT_W-1:0];
                    end
                    rmmp_pkg::REG_MODE: begin
                        r_mode <= i_cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end

            // a size write restarts the frame
            if (cfg_accept && (i_cfg_index == rmmp_pkg::REG_WIDTH ||
                               i_cfg_index == rmmp_pkg::REG_HEIGHT)) begin
                r_col <= '0;
                r_row <= '0;
            end else if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end

            if (accept && hold) begin
                r_held <= i_s_axis_tdata;
            end

            if (s1_free) begin
                r_s1_valid <= accept && emit;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_s1.part <= part;
            r_s1.lone <= lone_row;
            r_s1.eor  <= last_col;
            r_s1.eof  <= last_col && last_row;
        end
        if (out_free && r_s1_valid) begin
            r_out_data <= s1_res;
            r_out_eor  <= r_s1.eor;
            r_out_eof  <= r_s1.eof;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_eor;
    assign o_m_axis_tuser  = r_out_eof;

    // frame end is always also a row end
    a_eof_has_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tlast || !o_m_axis_tuser))
        else $error("end of frame without end of row");

    // column position stays inside the row
    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rmmp_pkg::CNT_W'(r_col) < w_eff))
        else $error("column count beyond row width");

    // both stages full and output stalled: no new pixel is taken
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("pixel accepted while pipeline is full");

    // a size write restarts the frame
    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && (i_cfg_index == rmmp_pkg::REG_WIDTH ||
                         i_cfg_index == rmmp_pkg::REG_HEIGHT))
        |=> (r_col == '0 && r_row == '0))
        else $error("frame position not cleared by size write");

    // output drains empty when nothing is staged behind the result leaving it
    a_out_refill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && !r_s1_valid) |=> !o_m_axis_tvalid)
        else $error("output valid without a staged result");

endmodule

// File: hdl/rmmp_ram.sv
// generic simple dual-port ram: one write port, one read port with registered data
// no dependencies

module rmmp_ram #(
    parameter int WIDTH  = 24,
    parameter int DEPTH  = 2,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds when no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: test/rgb_min_max_pool_2x2_unit_test.sv
`timescale 1ns / 1ps
// self-checking bench for rgb_min_max_pool_2x2_unit: a directed table, then random frames
// checked against a pooling predictor kept in the bench; depends on rmmp_pkg and the unit

module rgb_min_max_pool_2x2_unit_test;

    localparam int         LATENCY_CYC  = 8;
    localparam int         HOLD_CYC     = 400;
    localparam int         RANDOM_ITEMS = 480;
    localparam int         WIDE_ITEMS   = 48;
    localparam logic [1:0] REG_SPARE    = 2'd3;    // unmapped index, writes are dropped

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pixel;

    typedef struct packed {
        t_pixel pix;
        logic   eor;
        logic   eof;
    } t_pooled;

    typedef enum logic {ROW_CFG, ROW_PIX} t_row_kind;
    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_MOSTLY, RX_SPARSE} t_rx_mode;

    typedef struct {
        t_row_kind  kind;
        logic [1:0] idx;
        logic [15:0] value;
        t_pixel     pix;
        bit         typed;
        t_pooled    want;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [23:0] s_data;
    logic        m_valid;
    logic        m_ready;
    logic [23:0] m_data;
    logic        m_last;
    logic        m_user;

    rgb_min_max_pool_2x2_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last),
        .o_m_axis_tuser  (m_user)
    );

    // pooling predictor state
    logic [12:0] pred_width;
    logic [15:0] pred_height;
    logic        pred_max;
    int          row_pos;
    int          col_pos;
    t_pixel      held_pix;
    t_pixel      pair_buf [rmmp_pkg::BUF_DEPTH];

    t_pooled     pool_q [$];
    t_dir_row    dir_rows [$];

    int burst_left;
    int px_sent;
    int res_seen;
    int frames_seen;
    int cfg_writes;
    int err_count;
    bit hold_req;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("rgb_min_max_pool_2x2_unit regression: fail");
        $finish;
    end

    function automatic logic [7:0] pick8(logic [7:0] x, logic [7:0] y, logic take_max);
        if (take_max) begin
            return (x > y) ? x : y;
        end
        return (x < y) ? x : y;
    endfunction

    function automatic t_pixel fold_px(t_pixel a, t_pixel b, logic take_max);
        t_pixel res;
        res.red   = pick8(a.red, b.red, take_max);
        res.green = pick8(a.green, b.green, take_max);
        res.blue  = pick8(a.blue, b.blue, take_max);
        return res;
    endfunction

    function automatic t_pixel rgb(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        t_pixel px;
        px.red   = r;
        px.green = g;
        px.blue  = b;
        return px;
    endfunction

    // channels lean toward the rails so that ties and extremes come up often
    function automatic logic [7:0] rand_chan();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_pooled pooled(t_pixel px, logic eor, logic eof);
        t_pooled res;
        res.pix = px;
        res.eor = eor;
        res.eof = eof;
        return res;
    endfunction

    function automatic t_dir_row cfg_row(logic [1:0] idx, logic [15:0] value);
        t_dir_row row;
        row.kind  = ROW_CFG;
        row.idx   = idx;
        row.value = value;
        row.pix   = '0;
        row.typed = 1'b0;
        row.want  = '0;
        return row;
    endfunction

    function automatic t_dir_row pix_row(t_pixel px, bit typed, t_pooled want);
        t_dir_row row;
        row.kind  = ROW_PIX;
        row.idx   = '0;
        row.value = '0;
        row.pix   = px;
        row.typed = typed;
        row.want  = want;
        return row;
    endfunction

    function automatic void add_row(t_dir_row row);
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    function automatic void pool_reset();
        pred_width  = 13'd640;
        pred_height = 16'd480;
        pred_max    = 1'b1;
        row_pos     = 0;
        col_pos     = 0;
        held_pix    = '0;
    endfunction

    function automatic void pool_config(logic [1:0] idx, logic [15:0] value);
        case (idx)
            rmmp_pkg::REG_WIDTH: begin
                pred_width = value[12:0];
                row_pos    = 0;
                col_pos    = 0;
            end
            rmmp_pkg::REG_HEIGHT: begin
                pred_height = value;
                row_pos     = 0;
                col_pos     = 0;
            end
            rmmp_pkg::REG_MODE: begin
                pred_max = value[0];
            end
            default: begin
            end
        endcase
    endfunction

    // advances the predictor by one pixel; returns 1 when the pixel closes a block
    function automatic bit predict_pool(input t_pixel px, output t_pooled res);
        int     w;
        int     h;
        int     c;
        int     r;
        int     slot;
        bit     last_col;
        bit     last_row;
        bit     lone_row;
        bit     emit;
        t_pixel part;
        w = (pred_width == 0) ? 1 : ((pred_width > rmmp_pkg::MAX_WIDTH) ?
                                     rmmp_pkg::MAX_WIDTH : int'(pred_width));
        h = (pred_height == 0) ? 1 : int'(pred_height);
        c = col_pos;
        r = row_pos;
        slot = c >> 1;
        if (slot >= rmmp_pkg::BUF_DEPTH) begin
            slot = rmmp_pkg::BUF_DEPTH - 1;
        end
        last_col = (c + 1 == w);
        last_row = (r + 1 == h);
        lone_row = last_row && (h % 2 == 1);
        emit = 1'b0;
        res = '0;
        if (c % 2 == 0 && !last_col) begin
            held_pix = px;
        end else begin
            part = (c % 2 == 1) ? fold_px(held_pix, px, pred_max) : px;
            if (lone_row) begin
                res.pix = part;
                emit = 1'b1;
            end else if (r % 2 == 1) begin
                res.pix = fold_px(pair_buf[slot], part, pred_max);
                emit = 1'b1;
            end else begin
                pair_buf[slot] = part;
            end
        end
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) begin
                r = 0;
            end
        end
        col_pos = c;
        row_pos = r;
        res.eor = last_col;
        res.eof = last_col && last_row;
        return emit;
    endfunction

    function automatic void note_fail(string what, t_pooled want, t_pooled got);
        err_count++;
        if (err_count <= 10) begin
            $display("mismatch %0d (%s): expected r=%02h g=%02h b=%02h last=%b user=%b,",
                     err_count, what, want.pix.red, want.pix.green, want.pix.blue,
                     want.eor, want.eof);
            $display("    got r=%02h g=%02h b=%02h last=%b user=%b at %0t",
                     got.pix.red, got.pix.green, got.pix.blue, got.eor, got.eof, $realtime);
        end
    endfunction

    // sender works in bursts; a gap of idle cycles opens every time a burst runs out
    task automatic push_pixel(input t_pixel px, input bit typed, input t_pooled want);
        t_pooled got;
        bit      emit;
        if (burst_left == 0) begin
            @(negedge i_clk);
            s_valid <= 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 12);
        end
        @(negedge i_clk);
        s_valid <= 1'b1;
        s_data  <= px;
        do @(posedge i_clk); while (s_ready !== 1'b1);
        burst_left--;
        px_sent++;
        emit = predict_pool(px, got);
        if (emit) begin
            pool_q.insert(pool_q.size(), typed ? want : got);
        end
    endtask

    // registers change only with the pipe empty
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        @(negedge i_clk);
        s_valid <= 1'b0;
        while (pool_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY_CYC) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge i_clk); while (cfg_ready !== 1'b1);
        pool_config(idx, value);
        cfg_writes++;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // receiver: changing stall patterns, plus one long hold-off on request
    initial begin : rx_side
        t_rx_mode pat;
        int       pat_left;
        bit       held_off;
        pat = RX_OPEN;
        pat_left = 0;
        held_off = 1'b0;
        m_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !held_off) begin
                held_off = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYC - 1) @(negedge i_clk);
            end else begin
                if (pat_left == 0) begin
                    pat = t_rx_mode'($urandom_range(0, 3));
                    pat_left = $urandom_range(16, 96);
                end
                pat_left--;
                case (pat)
                    RX_OPEN:   m_ready <= 1'b1;
                    RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                    RX_MOSTLY: m_ready <= ($urandom_range(0, 4) != 0);
                    default:   m_ready <= (pat_left % 4 == 0);
                endcase
            end
        end
    end

    initial begin : out_check
        t_pooled got;
        t_pooled want;
        string   bad;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
                got.pix = m_data;
                got.eor = m_last;
                got.eof = m_user;
                res_seen++;
                if (got.eof === 1'b1) begin
                    frames_seen++;
                end
                if (pool_q.size() == 0) begin
                    note_fail("output with nothing pending", '0, got);
                end else begin
                    want = pool_q.pop_front();
                    bad = "";
                    if (got.pix.red !== want.pix.red) bad = {bad, " red"};
                    if (got.pix.green !== want.pix.green) bad = {bad, " green"};
                    if (got.pix.blue !== want.pix.blue) bad = {bad, " blue"};
                    if (got.eor !== want.eor) bad = {bad, " tlast"};
                    if (got.eof !== want.eof) bad = {bad, " tuser"};
                    if (bad != "") begin
                        note_fail({"wrong", bad}, want, got);
                    end
                end
            end
        end
    end

    initial begin : stim
        int          dir_px;
        int          w;
        int          h;
        int          frames;
        int          total;
        int          cut;
        int          split;
        int          guard;
        bit          hold_done;
        logic [15:0] wval;
        logic [15:0] hval;
        logic [15:0] mval;
        t_pixel      corner;

        i_rst_n     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        s_valid     = 1'b0;
        s_data      = '0;
        hold_req    = 1'b0;
        hold_done   = 1'b0;
        burst_left  = 0;
        px_sent     = 0;
        res_seen    = 0;
        frames_seen = 0;
        cfg_writes  = 0;
        err_count   = 0;
        pool_reset();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // 2x2 block in max then min mode, all-zero against all-ones
        add_row(cfg_row(rmmp_pkg::REG_WIDTH, 16'd2));
        add_row(cfg_row(rmmp_pkg::REG_HEIGHT, 16'd2));
        add_row(cfg_row(rmmp_pkg::REG_MODE, 16'd1));
        add_row(pix_row(rgb(8'h00, 8'h00, 8'h00), 0, '0));
        add_row(pix_row(rgb(8'hff, 8'hff, 8'hff), 0, '0));
        add_row(pix_row(rgb(8'h00, 8'h00, 8'h00), 0, '0));
        add_row(pix_row(rgb(8'h00, 8'h00, 8'h00), 1,
                        pooled(rgb(8'hff, 8'hff, 8'hff), 1, 1)));
        add_row(cfg_row(rmmp_pkg::REG_MODE, 16'd0));
        add_row(pix_row(rgb(8'hff, 8'hff, 8'hff), 0, '0));
        add_row(pix_row(rgb(8'h00, 8'h00, 8'h00), 0, '0));
        add_row(pix_row(rgb(8'hff, 8'hff, 8'hff), 0, '0));
        add_row(pix_row(rgb(8'hff, 8'hff, 8'hff), 1,
                        pooled(rgb(8'h00, 8'h00, 8'h00), 1, 1)));
        // 3x3: odd last column, lone last row and a corner pixel that passes through
        add_row(cfg_row(rmmp_pkg::REG_WIDTH, 16'd3));
        add_row(cfg_row(rmmp_pkg::REG_HEIGHT, 16'd3));
        add_row(cfg_row(rmmp_pkg::REG_MODE, 16'd1));
        add_row(pix_row(rgb(8'h12, 8'hab, 8'h5f), 0, '0));
        add_row(pix_row(rgb(8'h80, 8'h01, 8'hfe), 0, '0));
        add_row(pix_row(rgb(8'h7f, 8'hc3, 8'h20), 0, '0));
        add_row(pix_row(rgb(8'h00, 8'hff, 8'h10), 0, '0));
        add_row(pix_row(rgb(8'h55, 8'haa, 8'h33), 0, '0));
        add_row(pix_row(rgb(8'h01, 8'h02, 8'h03), 0, '0));
        add_row(pix_row(rgb(8'h9c, 8'h4e, 8'he7), 0, '0));
        add_row(pix_row(rgb(8'h3a, 8'hb1, 8'h0d), 0, '0));
        corner = rgb(8'hc8, 8'h64, 8'h96);
        add_row(pix_row(corner, 1, pooled(corner, 1, 1)));
        // zero width and height behave as 1x1; the unmapped index changes nothing
        add_row(cfg_row(rmmp_pkg::REG_WIDTH, 16'd0));
        add_row(cfg_row(rmmp_pkg::REG_HEIGHT, 16'd0));
        corner = rgb(8'hde, 8'had, 8'hbe);
        add_row(pix_row(corner, 1, pooled(corner, 1, 1)));
        add_row(cfg_row(REG_SPARE, 16'hffff));
        corner = rgb(8'h01, 8'h80, 8'hff);
        add_row(pix_row(corner, 1, pooled(corner, 1, 1)));

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                write_reg(dir_rows[i].idx, dir_rows[i].value);
            end else begin
                push_pixel(dir_rows[i].pix, dir_rows[i].typed, dir_rows[i].want);
            end
        end
        dir_px = px_sent;

        // random frames: mostly whole frames, some cut short or given a mode write mid-frame
        while (px_sent - dir_px < RANDOM_ITEMS) begin
            w = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 64) : $urandom_range(1, 9);
            h = $urandom_range(1, 6);
            frames = $urandom_range(1, 2);
            total = w * h * frames;
            cut = total;
            hval = 16'(h);
            if ($urandom_range(0, 5) == 0) begin
                cut = $urandom_range(1, total);
            end
            if ($urandom_range(0, 11) == 0) begin
                // tallest frame, abandoned after a few rows
                hval = 16'hffff;
                cut = $urandom_range(1, 3 * w);
            end
            if (!hold_done) begin
                // first frame is a whole 32x10 one, sent into the long output hold
                w = 32;
                h = 10;
                hval = 16'(h);
                cut = w * h;
            end
            if (cut > RANDOM_ITEMS - (px_sent - dir_px)) begin
                cut = RANDOM_ITEMS - (px_sent - dir_px);
            end
            wval = 16'($urandom);
            wval[12:0] = 13'(w);
            mval = 16'($urandom);
            write_reg(rmmp_pkg::REG_WIDTH, wval);
            write_reg(rmmp_pkg::REG_HEIGHT, hval);
            write_reg(rmmp_pkg::REG_MODE, mval);
            if ($urandom_range(0, 7) == 0) begin
                write_reg(REG_SPARE, 16'($urandom));
            end
            split = ($urandom_range(0, 3) == 0) ? $urandom_range(1, cut) : 0;
            if (!hold_done) begin
                hold_done = 1'b1;
                hold_req = 1'b1;
            end
            for (int n = 0; n < cut; n++) begin
                if (n == split && split != 0) begin
                    write_reg(rmmp_pkg::REG_MODE, 16'($urandom_range(0, 1)));
                end
                push_pixel(rgb(rand_chan(), rand_chan(), rand_chan()), 0, '0);
            end
        end

        // width field all ones saturates; one lone row, cut after a few dozen pixels
        write_reg(rmmp_pkg::REG_WIDTH, 16'hffff);
        write_reg(rmmp_pkg::REG_HEIGHT, 16'd1);
        write_reg(rmmp_pkg::REG_MODE, 16'($urandom_range(0, 1)));
        for (int n = 0; n < WIDE_ITEMS; n++) begin
            push_pixel(rgb(rand_chan(), rand_chan(), rand_chan()), 0, '0);
        end

        @(negedge i_clk);
        s_valid <= 1'b0;
        guard = 0;
        while (pool_q.size() != 0 && guard < 50000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (LATENCY_CYC) @(posedge i_clk);
        while (pool_q.size() != 0) begin
            note_fail("output never arrived", pool_q.pop_front(), '0);
        end

        $display("run: %0d pixels in, %0d pooled pixels out, %0d frames closed, %0d reg writes",
                 px_sent, res_seen, frames_seen, cfg_writes);
        $display("run: min and max modes, odd edges, cut frames and a %0d-cycle output hold",
                 HOLD_CYC);
        if (err_count == 0) begin
            $display("rgb_min_max_pool_2x2_unit regression: pass");
        end else begin
            $display("rgb_min_max_pool_2x2_unit regression: fail");
        end
        $finish;
    end

endmodule
